// ===== design/bfd_pkg.sv =====
package bfd_pkg;

  // Sizes of the supported images and blocks.
  localparam int MAX_SOURCE_WIDTH  = 2048;
  localparam int MAX_FACTOR        = 16;
  localparam int MAX_SOURCE_HEIGHT = 4096;

  // Register and field widths.
  localparam int FACTOR_W    = 5;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int PIX_W       = 8;

  // Position counters and block phases.
  localparam int COL_W  = $clog2(MAX_SOURCE_WIDTH);
  localparam int ROW_W  = $clog2(MAX_SOURCE_HEIGHT);
  localparam int SUB_W  = $clog2(MAX_FACTOR);
  localparam int STEP_W = 4;
  localparam int DIV_STEPS = ROW_W;

  // Sums and the rounding divide.
  localparam int HSUM_W      = 12;
  localparam int BAND_W      = 16;
  localparam int AREA_W      = 9;
  localparam int HALF_W      = AREA_W - 1;
  localparam int NUM_W       = BAND_W + 1;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUO_W       = NUM_W;
  localparam int QPROD_W     = QUO_W + AREA_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FACTOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // Register values after reset.
  localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;

  // Frame geometry after clamping.
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
  } frame_cfg_t;

  // One finished horizontal block segment handed from the front to the back.
  typedef struct packed {
    logic [HSUM_W-1:0] hsum;
    logic [COL_W-1:0]  block_col;
    logic              band_first;
    logic              band_last;
    logic              row_last;
    logic              frame_last;
  } blk_item_t;

  function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] v);
    logic [FACTOR_W-1:0] r;
    r = v;
    if (v == '0) r = FACTOR_W'(1);
    else if (v > FACTOR_W'(MAX_FACTOR)) r = FACTOR_W'(MAX_FACTOR);
    return r;
  endfunction

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    r = v;
    if (v == '0) r = WIDTH_W'(1);
    else if (v > WIDTH_W'(MAX_SOURCE_WIDTH)) r = WIDTH_W'(MAX_SOURCE_WIDTH);
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] r;
    r = v;
    if (v == '0) r = HEIGHT_W'(1);
    else if (v > HEIGHT_W'(MAX_SOURCE_HEIGHT)) r = HEIGHT_W'(MAX_SOURCE_HEIGHT);
    return r;
  endfunction

  // floor(2^17 / f^2), indexed by f - 1.
  function automatic logic [RECIP_W-1:0] recip(input logic [SUB_W-1:0] fm1);
    logic [RECIP_W-1:0] r;
    case (fm1)
      4'd0:    r = 18'd131072;
      4'd1:    r = 18'd32768;
      4'd2:    r = 18'd14563;
      4'd3:    r = 18'd8192;
      4'd4:    r = 18'd5242;
      4'd5:    r = 18'd3640;
      4'd6:    r = 18'd2674;
      4'd7:    r = 18'd2048;
      4'd8:    r = 18'd1618;
      4'd9:    r = 18'd1310;
      4'd10:   r = 18'd1083;
      4'd11:   r = 18'd910;
      4'd12:   r = 18'd775;
      4'd13:   r = 18'd668;
      4'd14:   r = 18'd582;
      default: r = 18'd512;
    endcase
    return r;
  endfunction

endpackage

// ===== design/box_filter_downscale.sv =====
// Channel   Signals                                          Transaction
// config    cfg_write, cfg_index, cfg_data                   write when cfg_write is high
// pixel in  pixel_valid, pixel_ready, pixel_value            valid and ready both high
// result    result_valid, result_ready, out_pixel,
//           row_end, frame_end                               valid and ready both high
//
// Pixels are taken one per clock while pixel_ready is high; a four-entry queue feeds the line-store pipeline.
// A result passes through stages s1, s2, s3, s4 and the output register after the pixel that completes its block.
// A write of block_factor starts a reblocking pass with pixel_ready low.
// Reset is synchronous and clears counters, queue and pipeline; the line store is not cleared.
// result_ready low while result_valid is high stalls the back pipeline; pixel_ready drops once the queue is full.
module box_filter_downscale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [bfd_pkg::PIX_W-1:0]        pixel_value,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [bfd_pkg::PIX_W-1:0]        out_pixel,
  output logic                             row_end,
  output logic                             frame_end
);
  import bfd_pkg::*;

  logic [FACTOR_W-1:0] block_factor;
  logic [WIDTH_W-1:0]  source_width;
  logic [HEIGHT_W-1:0] source_height;
  frame_cfg_t          cfg;
  logic                reblock_start;
  logic                push;
  blk_item_t           push_item;
  logic                queue_full;
  logic                pop;
  logic                head_valid;
  blk_item_t           head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_factor  <= RST_FACTOR;
      source_width  <= RST_WIDTH;
      source_height <= RST_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FACTOR: block_factor  <= cfg_data[FACTOR_W-1:0];
        REG_WIDTH:  source_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: source_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry; the front sees all of it, the back only the factor.
  assign cfg.factor    = eff_factor(block_factor);
  assign cfg.width     = eff_width(source_width);
  assign cfg.height    = eff_height(source_height);
  assign reblock_start = cfg_write && (cfg_index == REG_FACTOR);

  bfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .reblock_start (reblock_start),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel_value   (pixel_value),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  bfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .factor       (cfg.factor),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_pixel    (out_pixel),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

endmodule

// ===== design/bfd_front.sv =====
module bfd_front (
  input  logic                    clk,
  input  logic                    rst,
  input  bfd_pkg::frame_cfg_t     cfg,
  input  logic                    reblock_start,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [bfd_pkg::PIX_W-1:0] pixel_value,
  input  logic                    queue_full,
  output logic                    push,
  output bfd_pkg::blk_item_t      push_item
);
  import bfd_pkg::*;

  localparam int CW = COL_W + 2;
  localparam int RW = ROW_W + 2;

  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [SUB_W-1:0]  col_phase;
  logic [SUB_W-1:0]  row_phase;
  logic [COL_W-1:0]  block_col;
  logic [HSUM_W-1:0] hpartial;
  logic              busy;
  logic [STEP_W-1:0] step;

  // Divider registers of the reblocking pass: quotient shifts into the dividend.
  logic [ROW_W-1:0]  dvd_c;
  logic [ROW_W-1:0]  dvd_r;
  logic [SUB_W-1:0]  pr_c;
  logic [SUB_W-1:0]  pr_r;

  logic              accept;
  logic [SUB_W-1:0]  fm1;
  logic [ROW_W-1:0]  row_start;
  logic              col_fits;
  logic              row_fits;
  logic              in_block;
  logic              phase_end_c;
  logic              phase_end_r;
  logic              col_wrap;
  logic              row_wrap;
  logic [HSUM_W-1:0] hsum;
  logic [SUB_W:0]    trial_c;
  logic [SUB_W:0]    trial_r;
  logic              ge_c;
  logic              ge_r;

  assign pixel_ready = !busy && !queue_full;
  assign accept      = pixel_valid && pixel_ready;
  assign fm1         = SUB_W'(cfg.factor - FACTOR_W'(1));

  // Classify the pixel against the whole-block area of the frame.
  assign row_start   = row_count - ROW_W'(row_phase);
  assign col_fits    = (CW'(col_count) - CW'(col_phase) + CW'(cfg.factor)) <= CW'(cfg.width);
  assign row_fits    = (RW'(row_start) + RW'(cfg.factor)) <= RW'(cfg.height);
  assign in_block    = col_fits && row_fits;
  assign phase_end_c = (col_phase == fm1);
  assign phase_end_r = (row_phase == fm1);
  assign col_wrap    = (WIDTH_W'(col_count) + WIDTH_W'(1)) >= cfg.width;
  assign row_wrap    = (HEIGHT_W'(row_count) + HEIGHT_W'(1)) >= cfg.height;
  assign hsum        = (col_phase == '0) ? HSUM_W'(pixel_value)
                                         : hpartial + HSUM_W'(pixel_value);

  // A completed segment goes to the back part.
  assign push                 = accept && in_block && phase_end_c;
  assign push_item.hsum       = hsum;
  assign push_item.block_col  = block_col;
  assign push_item.band_first = (row_phase == '0);
  assign push_item.band_last  = phase_end_r;
  assign push_item.row_last   =
    (CW'(col_count) + CW'(1) + CW'(cfg.factor)) > CW'(cfg.width);
  assign push_item.frame_last = push_item.row_last &&
    ((RW'(row_start) + RW'({cfg.factor, 1'b0})) > RW'(cfg.height));

  // One restoring-division step for the column and the row counter.
  assign trial_c = {pr_c, dvd_c[ROW_W-1]};
  assign trial_r = {pr_r, dvd_r[ROW_W-1]};
  assign ge_c    = trial_c >= cfg.factor;
  assign ge_r    = trial_r >= cfg.factor;

  always_ff @(posedge clk) begin
    if (reblock_start) begin
      dvd_c <= ROW_W'(col_count);
      dvd_r <= row_count;
      pr_c  <= '0;
      pr_r  <= '0;
    end else if (busy && step != STEP_W'(DIV_STEPS)) begin
      dvd_c <= {dvd_c[ROW_W-2:0], ge_c};
      dvd_r <= {dvd_r[ROW_W-2:0], ge_r};
      pr_c  <= ge_c ? SUB_W'(trial_c - cfg.factor) : trial_c[SUB_W-1:0];
      pr_r  <= ge_r ? SUB_W'(trial_r - cfg.factor) : trial_r[SUB_W-1:0];
    end
  end

  // Position counters, horizontal partial sum and the reblocking pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      col_phase <= '0;
      row_phase <= '0;
      block_col <= '0;
      hpartial  <= '0;
      busy      <= 1'b0;
      step      <= '0;
    end else if (reblock_start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_W'(DIV_STEPS)) begin
        col_phase <= pr_c;
        block_col <= dvd_c[COL_W-1:0];
        row_phase <= pr_r;
        busy      <= 1'b0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end else if (accept) begin
      if (in_block) hpartial <= hsum;
      if (col_wrap) begin
        col_count <= '0;
        col_phase <= '0;
        block_col <= '0;
        if (row_wrap) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
          row_phase <= phase_end_r ? '0 : row_phase + SUB_W'(1);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
        col_phase <= phase_end_c ? '0 : col_phase + SUB_W'(1);
        if (phase_end_c) block_col <= block_col + COL_W'(1);
      end
    end
  end

endmodule

// ===== design/bfd_queue.sv =====
module bfd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bfd_pkg::blk_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output bfd_pkg::blk_item_t head
);
  import bfd_pkg::*;

  blk_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !do_pop)      count <= count + QCNT_W'(1);
      else if (do_pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== design/bfd_back.sv =====
module bfd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bfd_pkg::FACTOR_W-1:0] factor,
  input  logic                      head_valid,
  input  bfd_pkg::blk_item_t        head,
  output logic                      pop,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [bfd_pkg::PIX_W-1:0] out_pixel,
  output logic                      row_end,
  output logic                      frame_end
);
  import bfd_pkg::*;

  logic [BAND_W-1:0]  band_mem [MAX_SOURCE_WIDTH];
  logic [BAND_W-1:0]  rd_data;
  logic               fwd_hit;
  logic [BAND_W-1:0]  fwd_data;

  logic               adv;
  logic [AREA_W-1:0]  area;
  logic [HALF_W-1:0]  half;
  logic [RECIP_W-1:0] recip_val;

  logic               s1_valid;
  blk_item_t          s1_item;
  logic [BAND_W-1:0]  s1_old;
  logic [BAND_W-1:0]  s1_sum;

  logic               s2_valid;
  logic [NUM_W-1:0]   s2_num;
  logic               s2_row;
  logic               s2_frame;

  logic               s3_valid;
  logic [PROD_W-1:0]  s3_prod;
  logic [NUM_W-1:0]   s3_num;
  logic               s3_row;
  logic               s3_frame;
  logic [QUO_W-1:0]   s3_q0;

  logic               s4_valid;
  logic [QUO_W-1:0]   s4_q0;
  logic [QPROD_W-1:0] s4_qprod;
  logic [NUM_W-1:0]   s4_num;
  logic               s4_row;
  logic               s4_frame;
  logic [QPROD_W-1:0] s4_rem;
  logic [QUO_W-1:0]   s4_quo;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv = !result_valid || result_ready;
  assign pop = adv;

  assign area      = AREA_W'(factor * factor);
  assign half      = HALF_W'(area >> 1);
  assign recip_val = recip(SUB_W'(factor - FACTOR_W'(1)));

  // Column sum of the band; the previous write is forwarded on an address match.
  assign s1_old = fwd_hit ? fwd_data : rd_data;
  assign s1_sum = s1_item.band_first ? BAND_W'(s1_item.hsum)
                                     : s1_old + BAND_W'(s1_item.hsum);

  // Quotient estimate and its single correction step.
  assign s3_q0  = s3_prod[RECIP_SHIFT +: QUO_W];
  assign s4_rem = QPROD_W'(s4_num) - s4_qprod;
  assign s4_quo = (s4_rem >= QPROD_W'(area)) ? s4_q0 + QUO_W'(1) : s4_q0;

  // Line store of band column sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid) band_mem[s1_item.block_col] <= s1_sum;
      rd_data <= band_mem[head.block_col];
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data  <= s1_sum;
      s1_item   <= head;
      s2_num    <= NUM_W'(s1_sum) + NUM_W'(half);
      s2_row    <= s1_item.row_last;
      s2_frame  <= s1_item.frame_last;
      s3_prod   <= PROD_W'(s2_num) * PROD_W'(recip_val);
      s3_num    <= s2_num;
      s3_row    <= s2_row;
      s3_frame  <= s2_frame;
      s4_q0     <= s3_q0;
      s4_qprod  <= QPROD_W'(s3_q0) * QPROD_W'(area);
      s4_num    <= s3_num;
      s4_row    <= s3_row;
      s4_frame  <= s3_frame;
      out_pixel <= (s4_quo > QUO_W'(255)) ? PIX_W'(255) : s4_quo[PIX_W-1:0];
      row_end   <= s4_row;
      frame_end <= s4_frame;
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit      <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      fwd_hit      <= s1_valid && head_valid && (s1_item.block_col == head.block_col);
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid && s1_item.band_last;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid;
    end
  end

endmodule

// ===== design/bfd_checker.sv =====
module bfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_write,
  input logic [bfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input logic                             pixel_valid,
  input logic                             pixel_ready,
  input logic [bfd_pkg::PIX_W-1:0]        pixel_value,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [bfd_pkg::PIX_W-1:0]        out_pixel,
  input logic                             row_end,
  input logic                             frame_end
);
  import bfd_pkg::*;

  // A stalled result keeps its contents.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_pixel) && $stable(row_end) && $stable(frame_end))
    else $error("stalled result changed");

  // The last pixel of a frame is also the last of its row.
  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> row_end)
    else $error("frame_end without row_end");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A new block factor holds off pixels while the counters are reblocked.
  a_reblock_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index == REG_FACTOR) |=> !pixel_ready)
    else $error("pixel taken during reblocking");

endmodule

bind box_filter_downscale bfd_checker u_checker (.*);
